// ===== src/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_INC = 3'd4,
        CMD_DEC = 3'd5,
        CMD_CMP = 3'd6,
        CMD_NOP = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_FORM,
        OP_GCD,
        OP_DIVN,
        OP_DIVD,
        OP_DIV_STEP
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   mul1;
        logic   mul2;
        logic   form;
        logic   gcd_step;
        logic   div_start_n;
        logic   div_start_d;
        logic   div_step;
        logic   finish;
    } dp_cmd_t;

    typedef struct packed {
        logic   special;
        logic   is_cmp;
        logic   zero_num;
        logic   gcd_done;
        logic   div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/rau_datapath.sv =====
`default_nettype none
module rau_datapath #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic [2:0]         command,
    input  wire logic [31:0]        left_num,
    input  wire logic [30:0]        left_den,
    input  wire logic [31:0]        right_num,
    input  wire logic [30:0]        right_den,
    input  wire rau_pkg::dp_cmd_t   cmd,
    output rau_pkg::dp_stat_t       stat,
    output logic [63:0]             result_num,
    output logic [62:0]             result_den,
    output logic                    is_less,
    output logic                    is_equal,
    output logic                    is_greater,
    output logic                    status
);

    localparam int W = OPERAND_WIDTH;

    logic [2:0]         cmd_reg;
    logic signed [31:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [31:0] ln_w, rn_w;
    logic [63:0]        mn_reg, md_reg, a_reg, b_reg, q_reg, rem_reg, dvd_reg;
    logic [6:0]         shift_reg;
    logic [6:0]         cnt_reg;
    logic               neg_reg;
    logic               err_reg;
    logic               sel_reg;
    logic signed [63:0] n_sum, d_val;
    logic [63:0]        a_sub, rem_sh;
    logic [64:0]        trial;

    assign ln_w = 32'(signed'(left_num[W-1:0]));
    assign rn_w = 32'(signed'(right_num[W-1:0]));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= command;
            ln_reg  <= ln_w;
            rn_reg  <= rn_w;
            ld_reg  <= 32'(left_den[W-2:0]);
            rd_reg  <= 32'(right_den[W-2:0]);
            err_reg <= (left_den[W-2:0] == '0) || (right_den[W-2:0] == '0)
                    || (command == rau_pkg::CMD_DIV && rn_w == 0);
        end
        if (cmd.mul1) begin
            p0_reg <= ln_reg * ((cmd_reg == rau_pkg::CMD_MUL) ? rn_reg : rd_reg);
            p1_reg <= ld_reg * rn_reg;
        end
        if (cmd.mul2) begin
            p2_reg <= ld_reg * rd_reg;
        end
        if (cmd.form) begin
            neg_reg   <= (n_sum < 0) != (d_val < 0);
            mn_reg    <= (n_sum < 0) ? 64'(-n_sum) : 64'(n_sum);
            md_reg    <= (d_val < 0) ? 64'(-d_val) : 64'(d_val);
            a_reg     <= (n_sum < 0) ? 64'(-n_sum) : 64'(n_sum);
            b_reg     <= (d_val < 0) ? 64'(-d_val) : 64'(d_val);
            shift_reg <= '0;
        end
        if (cmd.gcd_step) begin
            if (!a_reg[0] && !b_reg[0]) begin
                a_reg     <= a_reg >> 1;
                b_reg     <= b_reg >> 1;
                shift_reg <= shift_reg + 7'd1;
            end else if (!a_reg[0]) begin
                a_reg <= a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_reg <= b_reg >> 1;
            end else if (a_reg >= b_reg) begin
                a_reg <= a_sub >> 1;
            end else begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end
        if (cmd.div_start_n || cmd.div_start_d) begin
            dvd_reg <= cmd.div_start_n ? mn_reg : md_reg;
            sel_reg <= cmd.div_start_d;
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= '0;
            if (cmd.div_start_n) begin
                a_reg <= (a_reg | b_reg) << shift_reg[5:0];
            end
        end
        if (cmd.div_step) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
            end else begin
                rem_reg <= rem_sh;
            end
            q_reg   <= {q_reg[62:0], ~trial[64]};
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + 7'd1;
        end
        if (cmd.finish) begin
            is_less    <= 1'b0;
            is_equal   <= 1'b0;
            is_greater <= 1'b0;
            result_num <= '0;
            result_den <= 63'd1;
            status     <= 1'b0;
            if (err_reg && cmd_reg != rau_pkg::CMD_NOP) begin
                status <= 1'b1;
            end else if (cmd_reg == rau_pkg::CMD_CMP) begin
                is_less    <= p0_reg < p1_reg;
                is_equal   <= p0_reg == p1_reg;
                is_greater <= p0_reg > p1_reg;
            end else if (cmd_reg != rau_pkg::CMD_NOP && mn_reg != 0) begin
                result_num <= neg_reg ? 64'(-mn_reg) : mn_reg;
                result_den <= md_reg[62:0];
            end
        end else if (cmd.div_step && cnt_reg == 7'd63) begin
            if (sel_reg) begin
                md_reg <= {q_reg[62:0], ~trial[64]};
            end else begin
                mn_reg <= {q_reg[62:0], ~trial[64]};
            end
        end
    end

    assign a_sub  = a_reg - b_reg;
    assign rem_sh = {rem_reg[62:0], dvd_reg[63]};
    assign trial  = {1'b0, rem_sh} - {1'b0, a_reg};

    always_comb begin
        case (cmd_reg)
            rau_pkg::CMD_ADD: n_sum = p0_reg + p1_reg;
            rau_pkg::CMD_SUB: n_sum = p0_reg - p1_reg;
            rau_pkg::CMD_MUL: n_sum = p0_reg;
            rau_pkg::CMD_DIV: n_sum = p0_reg;
            rau_pkg::CMD_INC: n_sum = 64'(ln_reg) + 64'(ld_reg);
            rau_pkg::CMD_DEC: n_sum = 64'(ln_reg) - 64'(ld_reg);
            default:          n_sum = '0;
        endcase
        case (cmd_reg)
            rau_pkg::CMD_DIV:                   d_val = p1_reg;
            rau_pkg::CMD_INC, rau_pkg::CMD_DEC: d_val = 64'(ld_reg);
            default:                            d_val = p2_reg;
        endcase
    end

    assign stat.special  = err_reg || cmd_reg == rau_pkg::CMD_NOP;
    assign stat.is_cmp   = cmd_reg == rau_pkg::CMD_CMP;
    assign stat.zero_num = mn_reg == 0;
    assign stat.gcd_done = (a_reg == 0) || (b_reg == 0);
    assign stat.div_done = cnt_reg == 7'd63;

endmodule
`default_nettype wire

// ===== src/rau_ctrl.sv =====
`default_nettype none
module rau_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output rau_pkg::dp_cmd_t        cmd,
    input  wire rau_pkg::dp_stat_t  stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_FORM, ST_GCD, ST_GFIX,
        ST_DIVN, ST_DIVD, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_v_reg;
    logic   second_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                cmd.load   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2 = 1'b1;
                state_next = (stat.special || stat.is_cmp) ? ST_FIN : ST_FORM;
            end
            ST_FORM: begin
                cmd.form   = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (stat.zero_num) begin
                    state_next = ST_FIN;
                end else if (stat.gcd_done) begin
                    state_next = ST_GFIX;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_GFIX: begin
                cmd.div_start_n = 1'b1;
                state_next      = ST_DIVN;
            end
            ST_DIVN: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = second_reg ? ST_FIN : ST_DIVD;
                end
            end
            ST_DIVD: begin
                cmd.div_start_d = 1'b1;
                state_next      = ST_DIVN;
            end
            ST_FIN: if (!out_v_reg || m_tready) begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            out_v_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.div_start_n) second_reg <= 1'b0;
            if (cmd.div_start_d) second_reg <= 1'b1;
            if (cmd.finish) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_v_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_tvalid || m_tready) else $error("pending result overwritten");
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> s_tready) else $error("load without ready");
    a_fin_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid) else $error("result lost");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
`endif

endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
`default_nettype none
// compare, error and unused command words go from the multiplies straight to the final write,
// a zero numerator after the form step; reduced results run a binary gcd loop and then divide
// numerator and denominator by the gcd in two 64-step restoring divisions; one word at a time,
// the next word is accepted only after the result of the last one is written
// a result held by m_tready stalls only the final write of the next word
// aresetn synchronous active low clears the controller and output valid
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata, // command, left_num, left_den, right_num, right_den
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata  // result_num, result_den, is_less, is_equal, is_greater, status
);

    rau_pkg::dp_cmd_t  cmd;
    rau_pkg::dp_stat_t stat;
    logic [63:0] rn;
    logic [62:0] rd;
    logic lt, eq, gt, st;

    rau_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .stat(stat)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .aclk(aclk), .command(s_tdata[2:0]), .left_num(s_tdata[34:3]),
        .left_den(s_tdata[65:35]), .right_num(s_tdata[97:66]),
        .right_den(s_tdata[128:98]), .cmd(cmd), .stat(stat),
        .result_num(rn), .result_den(rd), .is_less(lt), .is_equal(eq),
        .is_greater(gt), .status(st)
    );

    assign m_tdata = {5'd0, st, gt, eq, lt, rd, rn};

endmodule
`default_nettype wire
